FILE: rtl/core/shirm_pkg.sv
// ----------------------------------------------------------------------------
// shirm_pkg: shared types and constants of the shifting insert/remove array
// Field widths, request and status codes, and the per-cell command bundle.
// ----------------------------------------------------------------------------
package shirm_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W    = (POS_W > IDX_W) ? POS_W : IDX_W + 1;

  // read-side OR tree: groups of GRP cells, one register per group
  localparam int unsigned GRP      = 8;
  localparam int unsigned NGRP     = (CAPACITY + GRP - 1) / GRP;

  localparam int unsigned IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + ST_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET = 2'd0,
    REQ_SET = 2'd1,
    REQ_INS = 2'd2,
    REQ_REM = 2'd3
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // write action broadcast to every cell
  typedef enum logic [1:0] {
    COP_NONE = 2'd0,
    COP_SET  = 2'd1,
    COP_INS  = 2'd2,
    COP_REM  = 2'd3
  } cop_e;

  typedef struct packed {
    cop_e              op;
    logic              rd;     // drive selected cell onto read tree
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: rtl/core/shifting_insert_remove_array.sv
// Steps: decode/shift with group OR into the group registers, then final OR into the
//   output register.
// One request at a time; the next request is taken once the OR
//   tree has handed its result to the output register.
// The output register lets a new request enter while a result waits for m_axis_tready.
// Reset (rst_ni low, async): element count cleared, no result pending, FSM idle;
//   cell contents are left undefined and are never observed at or above the count.
// ----------------------------------------------------------------------------
// shifting_insert_remove_array: bounded ordered list with insert/remove
// A chain of cells shifts up on insert and down on remove, every cell in the same cycle;
// get reads through a two-level registered OR tree.
// ----------------------------------------------------------------------------
module shifting_insert_remove_array (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [shirm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // position[6:0], item_value[38:7]
  input  logic [shirm_pkg::REQ_W-1:0]         s_axis_tuser,  // req_type[1:0]
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [shirm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // read_value[31:0], status[33:32],
                                                             // count[40:34]
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_GATH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // latched request
  shirm_pkg::req_e               req_q;
  logic [shirm_pkg::POS_W-1:0]   pos_q;
  logic [shirm_pkg::DATA_W-1:0]  val_q;

  // element count and per-request status
  logic [shirm_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  shirm_pkg::status_e            st_q, st_d;

  // cell chain
  shirm_pkg::cell_cmd_t          cmd;
  logic [shirm_pkg::DATA_W-1:0]  cell_data [shirm_pkg::CAPACITY];
  logic [shirm_pkg::DATA_W-1:0]  cell_rd   [shirm_pkg::CAPACITY];

  // read OR tree
  logic [shirm_pkg::DATA_W-1:0]  grp_q [shirm_pkg::NGRP];
  logic [shirm_pkg::DATA_W-1:0]  grp_d [shirm_pkg::NGRP];
  logic [shirm_pkg::DATA_W-1:0]  rd_all;

  // output register
  logic                          out_valid_q;
  logic [shirm_pkg::DATA_W-1:0]  out_rd_q;
  shirm_pkg::status_e            out_st_q;
  logic [shirm_pkg::CNT_W-1:0]   out_cnt_q;

  logic in_xfer, out_xfer, out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;
  // result moves into the output register once it is free or draining
  assign out_load      = (state_q == S_GATH) && (!out_valid_q || m_axis_tready);

  // --------------------------------------------------------------------------
  // FSM
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) state_d = S_EXEC;
      S_EXEC: state_d = S_GATH;
      S_GATH: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= shirm_pkg::req_e'(s_axis_tuser);
      pos_q <= s_axis_tdata[shirm_pkg::POS_W-1:0];
      val_q <= s_axis_tdata[shirm_pkg::POS_W +: shirm_pkg::DATA_W];
    end
  end

  // --------------------------------------------------------------------------
  // Decode: range/full checks, cell command, new count. Active in S_EXEC only.
  // Insert checks range before full.
  // --------------------------------------------------------------------------
  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    cmd.op    = shirm_pkg::COP_NONE;
    cmd.rd    = 1'b0;
    cmd.pos   = pos_q;
    cmd.value = val_q;
    if (state_q == S_EXEC) begin
      st_d = shirm_pkg::ST_OK;
      if (req_q == shirm_pkg::REQ_INS) begin
        if (pos_q > cnt_q) begin
          st_d = shirm_pkg::ST_RANGE;
        end else if (cnt_q >= shirm_pkg::CNT_W'(shirm_pkg::CAPACITY)) begin
          st_d = shirm_pkg::ST_FULL;
        end else begin
          cmd.op = shirm_pkg::COP_INS;
          cnt_d  = cnt_q + 1'b1;
        end
      end else if (pos_q >= cnt_q) begin
        st_d = shirm_pkg::ST_RANGE;
      end else begin
        unique case (req_q)
          shirm_pkg::REQ_GET: cmd.rd = 1'b1;
          shirm_pkg::REQ_SET: cmd.op = shirm_pkg::COP_SET;
          shirm_pkg::REQ_REM: begin
            cmd.op = shirm_pkg::COP_REM;
            cnt_d  = cnt_q - 1'b1;
          end
          default: cmd.op = shirm_pkg::COP_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  // --------------------------------------------------------------------------
  // Cell chain: lower neighbor feeds insert shifts, upper feeds remove shifts.
  // Top cell takes itself on remove (its old value becomes stale anyway).
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < shirm_pkg::CAPACITY; g++) begin : g_cell
    logic [shirm_pkg::DATA_W-1:0] lower, upper;

    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[g-1];
    end

    if (g == shirm_pkg::CAPACITY - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_up
      assign upper = cell_data[g+1];
    end

    shirm_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (shirm_pkg::IDX_W'(g)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // --------------------------------------------------------------------------
  // Read tree: cells drive zero unless selected, so OR picks the hit.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int unsigned g = 0; g < shirm_pkg::NGRP; g++) begin
      grp_d[g] = '0;
      for (int unsigned k = 0; k < shirm_pkg::GRP; k++) begin
        if (g * shirm_pkg::GRP + k < shirm_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * shirm_pkg::GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      for (int unsigned g = 0; g < shirm_pkg::NGRP; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  always_comb begin
    rd_all = '0;
    for (int unsigned g = 0; g < shirm_pkg::NGRP; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rd_q  <= rd_all;
      out_st_q  <= st_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = shirm_pkg::OUT_TDATA_W'({out_cnt_q, out_st_q, out_rd_q});

`ifndef ASSERT_OFF
  // count never runs past the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= shirm_pkg::CNT_W'(shirm_pkg::CAPACITY))
    else $error("element count above capacity");

  // count only moves in the decode cycle
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC) |=> $stable(cnt_q))
    else $error("element count changed outside decode");

  // a successful insert grows the list by exactly one
  a_ins_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == shirm_pkg::COP_INS) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not increment count");

  // one request in flight: no new transfer right after one
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("request accepted while another in flight");
`endif

endmodule

FILE: rtl/core/shirm_cell.sv
// ----------------------------------------------------------------------------
// shirm_cell: one storage cell of the shifting array
// Holds one entry; loads, takes its lower or upper neighbor, or holds.
// ----------------------------------------------------------------------------
module shirm_cell (
  input  logic                             clk_i,
  input  logic [shirm_pkg::IDX_W-1:0]      idx_i,
  input  shirm_pkg::cell_cmd_t             cmd_i,
  input  logic [shirm_pkg::DATA_W-1:0]     lower_i,
  input  logic [shirm_pkg::DATA_W-1:0]     upper_i,
  output logic [shirm_pkg::DATA_W-1:0]     data_o,
  output logic [shirm_pkg::DATA_W-1:0]     rd_o
);

  logic [shirm_pkg::DATA_W-1:0] data_q, data_d;
  logic [shirm_pkg::CMP_W-1:0]  idx_ext, pos_ext;
  logic                         hit, above;

  assign idx_ext = shirm_pkg::CMP_W'(idx_i);
  assign pos_ext = shirm_pkg::CMP_W'(cmd_i.pos);
  assign hit     = (idx_ext == pos_ext);
  assign above   = (idx_ext > pos_ext);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      shirm_pkg::COP_SET: begin
        if (hit) data_d = cmd_i.value;
      end
      shirm_pkg::COP_INS: begin
        if (hit) data_d = cmd_i.value;
        else if (above) data_d = lower_i;
      end
      shirm_pkg::COP_REM: begin
        if (hit || above) data_d = upper_i;
      end
      default: data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (cmd_i.rd && hit) ? data_q : '0;

endmodule
